// ----- rtl/core/gamepad_change_event_generator_defines.svh -----
// Assertion helpers for the gamepad change event generator.
`ifndef GAMEPAD_CHANGE_EVENT_GENERATOR_DEFINES_SVH
`define GAMEPAD_CHANGE_EVENT_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold on every rising clock edge outside reset
`define GCEG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("gceg: assertion failed");

// expression must never be true outside reset
`define GCEG_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("gceg: forbidden condition seen");

`else

`define GCEG_ASSERT(lbl, clk, rst_n, prop)
`define GCEG_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- rtl/core/gceg_pkg.sv -----
package gceg_pkg;

	// slots served by the block; slot field width is fixed
	localparam int SLOTS     = 4;
	localparam int SLOT_W    = 2;
	localparam int SLOT_CNT  = 1 << SLOT_W;

	// event keys
	localparam int KEYS      = 20;
	localparam int AXES      = 4;
	localparam logic [4:0] KEY_LX = 5'd0;
	localparam logic [4:0] KEY_LT = 5'd4;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_TRIG_THR  = 2'd0,
		REG_IDLE_RLD  = 2'd1,
		REG_AXIS_MAX  = 2'd2,
		REG_AXIS_NEUT = 2'd3
	} cfg_reg_t;

	localparam logic [7:0] TRIG_THR_RST  = 8'd30;
	localparam logic [7:0] IDLE_RLD_RST  = 8'd100;
	localparam logic [7:0] AXIS_MAX_RST  = 8'd255;
	localparam logic [7:0] AXIS_NEUT_RST = 8'd128;

	// per-slot state word held in the state RAM
	typedef struct packed {
		logic        connected;
		logic [31:0] packet;
		logic [15:0] buttons;
		logic        left_pressed;
		logic        right_pressed;
		logic [7:0]  idle;
	} slot_state_t;

	localparam int STATE_W = $bits(slot_state_t);

	// event burst handed to the emitter: one mask bit per key
	typedef struct packed {
		logic [SLOT_W-1:0]     slot;
		logic [KEYS-1:0]       mask;
		logic [AXES-1:0][7:0]  axis_val;
		logic [KEYS-AXES-1:0]  bit_val;
	} gceg_plan_t;

endpackage

// ----- rtl/core/gceg_sample_if.sv -----
interface gceg_sample_if;
	import gceg_pkg::*;

	logic               valid;
	logic               ready;
	logic [SLOT_W-1:0]  slot;
	logic               present;
	logic [31:0]        packet_number;
	logic [15:0]        button_bits;
	logic [7:0]         left_trigger;
	logic [7:0]         right_trigger;
	logic signed [15:0] left_x;
	logic signed [15:0] left_y;
	logic signed [15:0] right_x;
	logic signed [15:0] right_y;

	modport source (
		output valid, slot, present, packet_number, button_bits,
		output left_trigger, right_trigger, left_x, left_y, right_x, right_y,
		input  ready
	);
	modport sink (
		input  valid, slot, present, packet_number, button_bits,
		input  left_trigger, right_trigger, left_x, left_y, right_x, right_y,
		output ready
	);
endinterface

// ----- rtl/core/gceg_event_if.sv -----
interface gceg_event_if;
	import gceg_pkg::*;

	logic              valid;
	logic              ready;
	logic [SLOT_W-1:0] event_slot;
	logic              is_axis;
	logic [4:0]        key_id;
	logic [7:0]        value;
	logic              last;

	modport source (
		output valid, event_slot, is_axis, key_id, value, last,
		input  ready
	);
	modport sink (
		input  valid, event_slot, is_axis, key_id, value, last,
		output ready
	);
endinterface

// ----- rtl/core/gceg_ram.sv -----
module gceg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/gceg_emitter.sv -----
module gceg_emitter import gceg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  gceg_plan_t   plan,
	output logic         free,
	gceg_event_if.source ev
);

	logic [KEYS-1:0]      mask_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [AXES-1:0][7:0] axis_val_q;
	logic [KEYS-AXES-1:0] bit_val_q;

	logic [4:0]           key;
	logic [4:0]           boff;
	logic                 last;
	logic [KEYS-1:0]      mask_rest;

	// lowest pending key goes out first
	always_comb begin
		key = KEY_LX;
		for (int i = KEYS - 1; i >= 0; i--) begin
			if (mask_q[i]) key = 5'(i);
		end
	end

	assign mask_rest = mask_q & (mask_q - KEYS'(1));
	assign last      = (mask_rest == '0);
	assign boff      = key - KEY_LT;

	assign ev.valid      = |mask_q;
	assign ev.event_slot = slot_q;
	assign ev.is_axis    = (key < KEY_LT);
	assign ev.key_id     = key;
	assign ev.value      = (key < KEY_LT) ? axis_val_q[key[1:0]]
	                                      : {7'd0, bit_val_q[boff[3:0]]};
	assign ev.last       = last;

	assign free = !ev.valid || (ev.ready && last);

	// pending mask: reload on a new burst, drop the key just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= plan.mask;
		end else if (ev.valid && ev.ready) begin
			mask_q <= mask_rest;
		end
	end

	// burst payload
	always_ff @(posedge clk) begin
		if (load) begin
			slot_q     <= plan.slot;
			axis_val_q <= plan.axis_val;
			bit_val_q  <= plan.bit_val;
		end
	end

endmodule

// ----- rtl/core/gamepad_change_event_generator.sv -----
// Gamepad change event generator.
// sample (sink): one poll word per slot; slot, present, packet number, buttons,
//   triggers and four signed stick axes. Accepted when valid and ready are high.
// event (source): one word per input event: slot, axis/button flag, key id,
//   value and a last flag on the final word caused by a sample.
// cfg_we/cfg_idx/cfg_wdata: register writes (threshold, idle reload, axis cap,
//   axis neutral), taken at any clock edge with cfg_we high.
// Timing: a sample is read from the per-slot state RAM in the cycle it is
//   accepted, evaluated the next cycle and written back once it leaves the
//   evaluate stage; its first event word is shown in the cycle after that.
//   A burst holds up to 20 events for a connect or disconnect.
// Throughput: one sample per cycle while samples cause no events; a sample
//   with events waits in the evaluate stage until the emitter has sent the
//   last word of the burst before it. The state RAM has one read and one write
//   port; a back-to-back access to the same slot is forwarded.
// Reset: all slots read as cleared (per-slot valid bits), registers take
//   their defaults. A stalled event channel holds the current word and,
//   once the evaluate stage fills, deasserts sample ready.
`include "gamepad_change_event_generator_defines.svh"

module gamepad_change_event_generator import gceg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	gceg_sample_if.sink  sample,
	gceg_event_if.source event_out,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [7:0]   cfg_wdata
);

	// configuration registers
	logic [7:0] trig_thr_q, idle_rld_q, axis_max_q, axis_neut_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_thr_q  <= TRIG_THR_RST;
			idle_rld_q  <= IDLE_RLD_RST;
			axis_max_q  <= AXIS_MAX_RST;
			axis_neut_q <= AXIS_NEUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_TRIG_THR:  trig_thr_q  <= cfg_wdata;
				REG_IDLE_RLD:  idle_rld_q  <= cfg_wdata;
				REG_AXIS_MAX:  axis_max_q  <= cfg_wdata;
				REG_AXIS_NEUT: axis_neut_q <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	function automatic logic [7:0] cap_axis(logic [16:0] sum, logic [7:0] amax);
		logic [8:0] sh;
		sh = sum[16:8];
		return (sh > {1'b0, amax}) ? amax : sh[7:0];
	endfunction

	// handshake and stage control
	logic              s1_valid_q;
	logic              s1_done;
	logic              has_ev;
	logic              em_free;
	logic              in_acc;
	logic              wr_en;
	slot_state_t       wr_state;

	assign in_acc       = sample.valid && sample.ready;
	assign sample.ready = !s1_valid_q || s1_done;

	// stage 1 sample registers
	logic [SLOT_W-1:0] slot_s1;
	logic              present_s1;
	logic [31:0]       pkt_s1;
	logic [15:0]       btn_s1;
	logic [7:0]        lt_s1, rt_s1;
	logic [15:0]       lx_s1, ly_s1, rx_s1, ry_s1;
	logic              fwd_s1;
	slot_state_t       fwd_state_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (sample.ready) begin
			s1_valid_q <= sample.valid;
			fwd_s1     <= sample.valid && wr_en && (slot_s1 == sample.slot);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			slot_s1      <= sample.slot;
			present_s1   <= sample.present;
			pkt_s1       <= sample.packet_number;
			btn_s1       <= sample.button_bits;
			lt_s1        <= sample.left_trigger;
			rt_s1        <= sample.right_trigger;
			lx_s1        <= sample.left_x;
			ly_s1        <= sample.left_y;
			rx_s1        <= sample.right_x;
			ry_s1        <= sample.right_y;
			fwd_state_s1 <= wr_state;
		end
	end

	// per-slot state RAM, entries read as cleared until first written
	logic [STATE_W-1:0] ram_rdata;
	logic [SLOT_CNT-1:0] written_q;

	gceg_ram #(
		.WIDTH (STATE_W),
		.DEPTH (SLOT_CNT)
	) u_state_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (slot_s1),
		.wdata (wr_state),
		.re    (in_acc),
		.raddr (sample.slot),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr_en) begin
			written_q[slot_s1] <= 1'b1;
		end
	end

	// evaluate the sample against the slot state
	slot_state_t cur;
	gceg_plan_t  plan;
	logic        slot_ok, lp, rp, changed;
	logic [15:0] bdiff;

	always_comb begin
		if (fwd_s1) begin
			cur = fwd_state_s1;
		end else if (written_q[slot_s1]) begin
			cur = slot_state_t'(ram_rdata);
		end else begin
			cur = '0;
		end

		slot_ok  = ({1'b0, slot_s1} < (SLOT_W + 1)'(SLOTS));
		lp       = (lt_s1 >= trig_thr_q);
		rp       = (rt_s1 >= trig_thr_q);
		changed  = !cur.connected || (cur.packet != pkt_s1);
		bdiff    = btn_s1 ^ cur.buttons;
		wr_state = cur;

		plan.slot     = slot_s1;
		plan.mask     = '0;
		plan.axis_val = '0;
		plan.bit_val  = '0;

		if (cur.idle != 8'd0) begin
			wr_state.idle = cur.idle - 8'd1;
		end else if (present_s1) begin
			wr_state.connected = 1'b1;
			if (changed) begin
				plan.mask[3:0]     = '1;
				plan.mask[4]       = (lp != cur.left_pressed);
				plan.mask[5]       = (rp != cur.right_pressed);
				plan.mask[19:6]    = {bdiff[15:12], bdiff[9:0]};
				plan.axis_val[0]   = cap_axis({1'b0, ~lx_s1[15], lx_s1[14:0]}, axis_max_q);
				plan.axis_val[1]   = cap_axis(17'h08000 - {ly_s1[15], ly_s1}, axis_max_q);
				plan.axis_val[2]   = cap_axis({1'b0, ~rx_s1[15], rx_s1[14:0]}, axis_max_q);
				plan.axis_val[3]   = cap_axis(17'h08000 - {ry_s1[15], ry_s1}, axis_max_q);
				plan.bit_val       = {btn_s1[15:12], btn_s1[9:0], rp, lp};
				wr_state.left_pressed  = lp;
				wr_state.right_pressed = rp;
				wr_state.buttons       = btn_s1;
				wr_state.packet        = pkt_s1;
			end
		end else begin
			if (cur.connected) begin
				plan.mask     = '1;
				plan.axis_val = {AXES{axis_neut_q}};
				wr_state.left_pressed  = 1'b0;
				wr_state.right_pressed = 1'b0;
				wr_state.buttons       = '0;
			end
			wr_state.idle      = idle_rld_q;
			wr_state.connected = 1'b0;
		end

		if (!slot_ok) begin
			plan.mask = '0;
		end
	end

	assign has_ev  = |plan.mask;
	assign s1_done = s1_valid_q && (!has_ev || em_free);
	assign wr_en   = s1_done && slot_ok;

	// event serializer
	gceg_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (s1_done && has_ev),
		.plan   (plan),
		.free   (em_free),
		.ev     (event_out)
	);

	// last word of a burst taken with no new burst loaded behind it
	logic ev_drained;

	assign ev_drained = event_out.valid && event_out.ready && event_out.last
		&& !(s1_done && has_ev);

	// checks
	`GCEG_ASSERT_NEVER(a_stall_only_busy, clk, arst_n, s1_valid_q && !s1_done && !event_out.valid)
	`GCEG_ASSERT(a_accept_fills_s1, clk, arst_n, in_acc |=> s1_valid_q)
	`GCEG_ASSERT(a_fwd_after_write, clk, arst_n, (in_acc && wr_en && (sample.slot == slot_s1)) |=> fwd_s1)
	`GCEG_ASSERT(a_last_not_drained, clk, arst_n, ev_drained |=> !event_out.valid)

endmodule
